/* hdl/ptdm_pkg.sv */
// Shared types, constants and helpers of the periodic task deadline monitor.
package ptdm_pkg;

	localparam int NUM_TASKS       = 5;
	localparam int NUM_PERIOD_REGS = 5;
	localparam int TASK_W          = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int PREG_W          = $clog2(NUM_PERIOD_REGS);
	localparam int TIME_W          = 32;
	localparam int CMD_W           = 2;
	localparam int TID_W           = 3;
	localparam int REG_IDX_W       = 3;

	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN     = 2'd0,
		CMD_JOB_START = 2'd1,
		CMD_JOB_END   = 2'd2,
		CMD_UNUSED    = 2'd3
	} cmd_t;

	localparam logic [REG_IDX_W-1:0] REG_TEST_DURATION = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_START_OFFSET  = 3'd6;

	localparam time_t PERIOD_RESET [NUM_PERIOD_REGS] = '{
		32'd4000, 32'd3000, 32'd10000, 32'd10000, 32'd5000
	};
	localparam time_t DURATION_RESET = 32'd10000000;
	localparam time_t OFFSET_RESET   = 32'd0;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		time_t   a;
		time_t   b;
	} alu_req_t;

	typedef struct packed {
		time_t sum;
		logic  carry;
	} alu_rsp_t;

	function automatic logic [PREG_W-1:0] period_slot(input logic [TASK_W-1:0] t);
		if (32'(t) < NUM_PERIOD_REGS) begin
			return PREG_W'(t);
		end
		return PREG_W'(NUM_PERIOD_REGS - 1);
	endfunction

endpackage

/* hdl/ptdm_alu.sv */
// Shared 32-bit add/subtract unit; carry out set on subtract means no borrow.
module ptdm_alu
	import ptdm_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [TIME_W:0] full;

	assign full = {1'b0, req.a}
		+ {1'b0, (req.op == ALU_SUB) ? ~req.b : req.b}
		+ (TIME_W+1)'(req.op == ALU_SUB);

	assign rsp.sum   = full[TIME_W-1:0];
	assign rsp.carry = full[TIME_W];

endmodule

/* hdl/periodic_task_deadline_monitor_unit.sv */
// Top level of the periodic task deadline monitor: registers, sequencer, result ports.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | start / busy       | command, task_index, now_time
//  config   | wr_en              | wr_index, wr_data
//  result   | result_valid       | is_summary, task_id, violation_now,
//           |                    | violation_count, job_count, first_begin_time,
//           |                    | first_end_time, start_time_out, last_item
//
// One 32-bit adder does every sum and compare on time values, one operation per cycle.
// Begin: offset add, one deadline add per task, result beat. Job event: elapsed
// subtract, end-of-test check, then violation compare, deadline advance (job end
// only), result beat; past end of test, one summary beat per task. Dropped events leave busy low.
// Reset restores register defaults and leaves monitoring inactive.
// Result beats cannot be stalled.
module periodic_task_deadline_monitor_unit
	import ptdm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [TID_W-1:0]     task_index,
	input  logic [TIME_W-1:0]    now_time,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TIME_W-1:0]    wr_data,
	output logic                 result_valid,
	output logic                 is_summary,
	output logic [TID_W-1:0]     task_id,
	output logic                 violation_now,
	output logic [TIME_W-1:0]    violation_count,
	output logic [TIME_W-1:0]    job_count,
	output logic [TIME_W-1:0]    first_begin_time,
	output logic [TIME_W-1:0]    first_end_time,
	output logic [TIME_W-1:0]    start_time_out,
	output logic                 last_item
);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_BEG_START = 9'b000000010,
		ST_BEG_SWEEP = 9'b000000100,
		ST_EV_ELAPS  = 9'b000001000,
		ST_EV_CHECK  = 9'b000010000,
		ST_EV_VIOL   = 9'b000100000,
		ST_EV_ADV    = 9'b001000000,
		ST_EMIT      = 9'b010000000,
		ST_SUMMARY   = 9'b100000000
	} state_t;

	localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

	state_t             state_q;
	logic               active_q;
	cmd_t               cmd_q;
	logic [TASK_W-1:0]  idx_q;
	time_t              now_q;
	time_t              start_q;
	time_t              elapsed_q;
	logic               viol_now_q;

	time_t period_q [NUM_PERIOD_REGS];
	time_t duration_q;
	time_t offset_q;

	time_t rel_q   [NUM_TASKS];
	time_t dl_q    [NUM_TASKS];
	time_t jobs_q  [NUM_TASKS];
	time_t viols_q [NUM_TASKS];
	time_t fb_q    [NUM_TASKS];
	time_t fe_q    [NUM_TASKS];

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	time_t    period_cur;
	logic     accept;
	logic     task_ok;

	ptdm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign accept     = start && !busy;
	assign task_ok    = 32'(task_index) < NUM_TASKS;
	assign period_cur = period_q[period_slot(idx_q)];

	always_comb begin
		alu_req = '{op: ALU_ADD, a: now_q, b: offset_q};
		unique case (state_q)
			ST_BEG_SWEEP: alu_req = '{op: ALU_ADD, a: start_q, b: period_cur};
			ST_EV_ELAPS:  alu_req = '{op: ALU_SUB, a: now_q, b: start_q};
			ST_EV_CHECK:  alu_req = '{op: ALU_SUB, a: duration_q, b: elapsed_q};
			ST_EV_VIOL: begin
				if (cmd_q == CMD_JOB_START) begin
					alu_req = '{op: ALU_SUB, a: now_q, b: rel_q[idx_q]};
				end else begin
					alu_req = '{op: ALU_SUB, a: dl_q[idx_q], b: now_q};
				end
			end
			ST_EV_ADV:    alu_req = '{op: ALU_ADD, a: dl_q[idx_q], b: period_cur};
			default:      alu_req = '{op: ALU_ADD, a: now_q, b: offset_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
				period_q[i] <= PERIOD_RESET[i];
			end
			duration_q <= DURATION_RESET;
			offset_q   <= OFFSET_RESET;
		end else if (wr_en) begin
			if (32'(wr_index) < NUM_PERIOD_REGS) begin
				period_q[wr_index[PREG_W-1:0]] <= wr_data;
			end else if (wr_index == REG_TEST_DURATION) begin
				duration_q <= wr_data;
			end else if (wr_index == REG_START_OFFSET) begin
				offset_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd_t'(command) == CMD_BEGIN) begin
							state_q <= ST_BEG_START;
						end else if (cmd_t'(command) != CMD_UNUSED && active_q && task_ok) begin
							idx_q   <= task_index[TASK_W-1:0];
							state_q <= ST_EV_ELAPS;
						end
					end
				end
				ST_BEG_START: begin
					active_q <= 1'b1;
					idx_q    <= '0;
					state_q  <= ST_BEG_SWEEP;
				end
				ST_BEG_SWEEP: begin
					if (idx_q == LAST_TASK) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EV_ELAPS: state_q <= ST_EV_CHECK;
				ST_EV_CHECK: begin
					if (!alu_rsp.carry) begin
						active_q <= 1'b0;
						idx_q    <= '0;
						state_q  <= ST_SUMMARY;
					end else begin
						state_q <= ST_EV_VIOL;
					end
				end
				ST_EV_VIOL: state_q <= (cmd_q == CMD_JOB_END) ? ST_EV_ADV : ST_EMIT;
				ST_EV_ADV:  state_q <= ST_EMIT;
				ST_EMIT:    state_q <= ST_IDLE;
				ST_SUMMARY: begin
					if (idx_q == LAST_TASK) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			now_q <= now_time;
		end
		unique case (state_q)
			ST_BEG_START: begin
				start_q    <= alu_rsp.sum;
				viol_now_q <= 1'b0;
			end
			ST_BEG_SWEEP: begin
				dl_q[idx_q]    <= alu_rsp.sum;
				rel_q[idx_q]   <= start_q;
				jobs_q[idx_q]  <= '0;
				viols_q[idx_q] <= '0;
				fb_q[idx_q]    <= '0;
				fe_q[idx_q]    <= '0;
			end
			ST_EV_ELAPS: begin
				elapsed_q <= alu_rsp.sum;
				if (cmd_q == CMD_JOB_START && fb_q[idx_q] == '0) begin
					fb_q[idx_q] <= now_q;
				end
				if (cmd_q == CMD_JOB_END && fe_q[idx_q] == '0) begin
					fe_q[idx_q] <= now_q;
				end
			end
			ST_EV_VIOL: begin
				viol_now_q <= !alu_rsp.carry;
				if (!alu_rsp.carry) begin
					viols_q[idx_q] <= viols_q[idx_q] + 1'b1;
				end
				if (cmd_q == CMD_JOB_END) begin
					jobs_q[idx_q] <= jobs_q[idx_q] + 1'b1;
					rel_q[idx_q]  <= dl_q[idx_q];
				end
			end
			ST_EV_ADV: dl_q[idx_q] <= alu_rsp.sum;
			default: begin
			end
		endcase
	end

	assign busy             = (state_q != ST_IDLE);
	assign result_valid     = (state_q == ST_EMIT) || (state_q == ST_SUMMARY);
	assign is_summary       = (state_q == ST_SUMMARY);
	assign task_id          = TID_W'(idx_q);
	assign violation_now    = (state_q == ST_EMIT) && viol_now_q;
	assign violation_count  = viols_q[idx_q];
	assign job_count        = jobs_q[idx_q];
	assign first_begin_time = fb_q[idx_q];
	assign first_end_time   = fe_q[idx_q];
	assign start_time_out   = start_q;
	assign last_item        = (state_q == ST_EMIT) || (idx_q == LAST_TASK);

endmodule

/* hdl/ptdm_checker.sv */
// Port-level checker of the periodic task deadline monitor and its bind.
module ptdm_checker
	import ptdm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [CMD_W-1:0]  command,
	input logic              result_valid,
	input logic              is_summary,
	input logic              violation_now,
	input logic              last_item
);

	a_beat_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result beat while not busy");

	a_begin_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_BEGIN) |=> busy)
		else $error("begin command did not start work");

	a_summary_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && is_summary && !last_item) |=> (result_valid && is_summary))
		else $error("summary beats not contiguous");

	a_event_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !is_summary) |-> last_item)
		else $error("event result not marked last");

	a_summary_no_viol: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && is_summary) |-> !violation_now)
		else $error("summary beat flags a violation");

endmodule

bind periodic_task_deadline_monitor_unit ptdm_checker u_ptdm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid),
	.is_summary   (is_summary),
	.violation_now(violation_now),
	.last_item    (last_item)
);

/* sim/tb.sv */
// Testbench of the periodic task deadline monitor: command beats checked against a predictor.
`timescale 1ns / 1ps

module tb;
	import ptdm_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		cmd_t             cmd;
		logic [TID_W-1:0] tidx;
		time_t            now;
	} cmd_beat_t;

	typedef struct {
		logic             summary;
		logic [TID_W-1:0] tid;
		logic             viol;
		time_t            viol_cnt;
		time_t            jobs;
		time_t            fbegin;
		time_t            fend;
		time_t            t_start;
		logic             last;
	} status_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CMD_W-1:0]     command = '0;
	logic [TID_W-1:0]     task_index = '0;
	logic [TIME_W-1:0]    now_time = '0;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [TIME_W-1:0]    wr_data = '0;
	logic                 result_valid;
	logic                 is_summary;
	logic [TID_W-1:0]     task_id;
	logic                 violation_now;
	logic [TIME_W-1:0]    violation_count;
	logic [TIME_W-1:0]    job_count;
	logic [TIME_W-1:0]    first_begin_time;
	logic [TIME_W-1:0]    first_end_time;
	logic [TIME_W-1:0]    start_time_out;
	logic                 last_item;

	periodic_task_deadline_monitor_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.task_index       (task_index),
		.now_time         (now_time),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.result_valid     (result_valid),
		.is_summary       (is_summary),
		.task_id          (task_id),
		.violation_now    (violation_now),
		.violation_count  (violation_count),
		.job_count        (job_count),
		.first_begin_time (first_begin_time),
		.first_end_time   (first_end_time),
		.start_time_out   (start_time_out),
		.last_item        (last_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register mirror
	time_t cfg_period [NUM_PERIOD_REGS];
	time_t cfg_duration;
	time_t cfg_offset;

	// monitor state mirror
	logic  mon_active;
	time_t mon_start;
	time_t rel_t     [NUM_TASKS];
	time_t dl_t      [NUM_TASKS];
	time_t n_jobs    [NUM_TASKS];
	time_t n_viol    [NUM_TASKS];
	time_t t_fbegin  [NUM_TASKS];
	time_t t_fend    [NUM_TASKS];

	cmd_beat_t    pending_cmds [$];
	status_beat_t expected_status [$];
	cmd_beat_t    beat_out;
	status_beat_t want;

	logic  took = 1'b0;
	logic  quiet = 1'b0;
	int    err_count = 0;
	int    cmds_taken = 0;
	int    status_seen = 0;
	int    summaries_seen = 0;

	// generator view of the monitor
	logic  gen_active = 1'b0;
	time_t gen_start = '0;
	logic  end_next [NUM_TASKS];

	function automatic void push_status(logic summary, int t, logic viol, logic last);
		status_beat_t s;
		s.summary  = summary;
		s.tid      = TID_W'(t);
		s.viol     = viol;
		s.viol_cnt = n_viol[t];
		s.jobs     = n_jobs[t];
		s.fbegin   = t_fbegin[t];
		s.fend     = t_fend[t];
		s.t_start  = mon_start;
		s.last     = last;
		expected_status.push_back(s);
	endfunction

	function automatic void apply_command(cmd_beat_t b);
		int    t;
		logic  viol;
		time_t per;
		t = int'(b.tidx);
		viol = 1'b0;
		if (b.cmd == CMD_BEGIN) begin
			mon_active = 1'b1;
			mon_start = b.now + cfg_offset;
			for (int i = 0; i < NUM_TASKS; i++) begin
				per = cfg_period[(i < NUM_PERIOD_REGS) ? i : NUM_PERIOD_REGS - 1];
				t_fbegin[i] = '0;
				t_fend[i] = '0;
				n_jobs[i] = '0;
				n_viol[i] = '0;
				rel_t[i] = mon_start;
				dl_t[i] = mon_start + per;
			end
			push_status(1'b0, 0, 1'b0, 1'b1);
			return;
		end
		if (b.cmd == CMD_UNUSED || !mon_active || t >= NUM_TASKS) begin
			return;
		end
		if (b.cmd == CMD_JOB_START) begin
			if (t_fbegin[t] == '0) begin
				t_fbegin[t] = b.now;
			end
		end else if (t_fend[t] == '0) begin
			t_fend[t] = b.now;
		end
		if (time_t'(b.now - mon_start) > cfg_duration) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				push_status(1'b1, i, 1'b0, i == NUM_TASKS - 1);
			end
			mon_active = 1'b0;
			return;
		end
		if (b.cmd == CMD_JOB_START) begin
			if (b.now < rel_t[t]) begin
				n_viol[t]++;
				viol = 1'b1;
			end
		end else begin
			per = cfg_period[(t < NUM_PERIOD_REGS) ? t : NUM_PERIOD_REGS - 1];
			n_jobs[t]++;
			if (b.now > dl_t[t]) begin
				n_viol[t]++;
				viol = 1'b1;
			end
			rel_t[t] = dl_t[t];
			dl_t[t] = dl_t[t] + per;
		end
		push_status(1'b0, t, viol, 1'b1);
	endfunction

	function automatic void check_field(string fname, time_t exp_v, time_t got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", fname, exp_v, got_v);
			err_count++;
		end
	endfunction

	// returns 1 when the beat is expected to produce a result
	function automatic bit enqueue(cmd_t c, logic [TID_W-1:0] t, time_t at);
		cmd_beat_t b;
		b.cmd = c;
		b.tidx = t;
		b.now = at;
		pending_cmds.push_back(b);
		if (c == CMD_BEGIN) begin
			gen_active = 1'b1;
			gen_start = at + cfg_offset;
			return 1'b1;
		end
		if (c == CMD_UNUSED || !gen_active || int'(t) >= NUM_TASKS) begin
			return 1'b0;
		end
		if (time_t'(at - gen_start) > cfg_duration) begin
			gen_active = 1'b0;
		end
		return 1'b1;
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 31)) begin
				beat_out = pending_cmds.pop_front();
				start <= 1'b1;
				command <= beat_out.cmd;
				task_index <= beat_out.tidx;
				now_time <= beat_out.now;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				if (expected_status.size() == 0) begin
					$error("result beat with nothing expected (task_id %0d)", task_id);
					err_count++;
				end else begin
					want = expected_status.pop_front();
					check_field("is_summary", time_t'(want.summary), time_t'(is_summary));
					check_field("task_id", time_t'(want.tid), time_t'(task_id));
					check_field("violation_now", time_t'(want.viol), time_t'(violation_now));
					check_field("violation_count", want.viol_cnt, violation_count);
					check_field("job_count", want.jobs, job_count);
					check_field("first_begin_time", want.fbegin, first_begin_time);
					check_field("first_end_time", want.fend, first_end_time);
					check_field("start_time_out", want.t_start, start_time_out);
					check_field("last_item", time_t'(want.last), time_t'(last_item));
					status_seen++;
					if (is_summary) begin
						summaries_seen++;
					end
				end
			end
			took = start && !busy;
			if (took) begin
				beat_out.cmd = cmd_t'(command);
				beat_out.tidx = task_index;
				beat_out.now = now_time;
				apply_command(beat_out);
				cmds_taken++;
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || wr_en) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input time_t val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (int'(idx) < NUM_PERIOD_REGS) begin
			cfg_period[idx] = val;
		end else if (idx == REG_TEST_DURATION) begin
			cfg_duration = val;
		end else if (idx == REG_START_OFFSET) begin
			cfg_offset = val;
		end
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic program_regs(input time_t p_lo, input time_t p_hi, input time_t dur,
		input time_t off);
		for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
			write_reg(REG_IDX_W'(i), (p_lo == p_hi) ? p_lo : time_t'($urandom_range(p_hi, p_lo)));
		end
		write_reg(REG_TEST_DURATION, dur);
		write_reg(REG_START_OFFSET, off);
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
		end while (pending_cmds.size() != 0 || start || busy || expected_status.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int unsigned step_max);
		int               made;
		int               r;
		time_t            t_now;
		time_t            at;
		cmd_t             c;
		logic [TID_W-1:0] tk;
		made = 0;
		t_now = $urandom();
		for (int i = 0; i < NUM_TASKS; i++) begin
			end_next[i] = 1'b0;
		end
		while (made < n) begin
			r = $urandom_range(99);
			at = t_now;
			tk = TID_W'($urandom());
			if (!gen_active || r < 2) begin
				t_now += $urandom_range(step_max);
				at = t_now;
				c = CMD_BEGIN;
			end else if (r < 6) begin
				c = CMD_UNUSED;
				at = $urandom();
			end else if (r < 10) begin
				c = r[0] ? CMD_JOB_START : CMD_JOB_END;
				tk = TID_W'($urandom_range(7, NUM_TASKS));
			end else if (r < 13) begin
				c = cmd_t'($urandom_range(CMD_JOB_END, CMD_JOB_START));
				tk = TID_W'($urandom_range(NUM_TASKS - 1));
				at = $urandom();
			end else begin
				tk = TID_W'($urandom_range(NUM_TASKS - 1));
				c = end_next[tk] ? CMD_JOB_END : CMD_JOB_START;
				end_next[tk] = !end_next[tk];
				t_now += $urandom_range(step_max);
				at = t_now;
			end
			made += enqueue(c, tk, at);
			if (c == CMD_BEGIN) begin
				t_now = gen_start;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
			cfg_period[i] = PERIOD_RESET[i];
		end
		cfg_duration = DURATION_RESET;
		cfg_offset = OFFSET_RESET;
		mon_active = 1'b0;
		mon_start = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			rel_t[i] = '0;
			dl_t[i] = '0;
			n_jobs[i] = '0;
			n_viol[i] = '0;
			t_fbegin[i] = '0;
			t_fend[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// reset register values
		void'(enqueue(CMD_JOB_START, 3'd0, 32'd100));
		void'(enqueue(CMD_UNUSED, 3'd3, 32'hFFFF_FFFF));
		void'(enqueue(CMD_BEGIN, 3'd7, 32'd1000));
		void'(enqueue(CMD_JOB_START, 3'd0, 32'd500));
		void'(enqueue(CMD_JOB_END, 3'd0, 32'd6000));
		void'(enqueue(CMD_JOB_START, 3'd1, 32'd2000));
		void'(enqueue(CMD_JOB_END, 3'd1, 32'd3500));
		void'(enqueue(CMD_JOB_START, 3'd5, 32'd2000));
		void'(enqueue(CMD_JOB_END, 3'd7, 32'd2000));
		void'(enqueue(CMD_UNUSED, 3'd0, 32'd0));
		void'(enqueue(CMD_JOB_END, 3'd4, 32'd10001000));
		void'(enqueue(CMD_JOB_START, 3'd3, 32'd10001001));
		void'(enqueue(CMD_JOB_END, 3'd2, 32'd20000000));
		void'(enqueue(CMD_BEGIN, 3'd0, 32'd0));
		void'(enqueue(CMD_JOB_START, 3'd2, 32'd0));
		void'(enqueue(CMD_JOB_START, 3'd2, 32'd7));
		void'(enqueue(CMD_JOB_END, 3'd2, 32'd0));
		void'(enqueue(CMD_JOB_END, 3'd2, 32'd9));
		drain();

		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		void'(enqueue(CMD_BEGIN, 3'd0, 32'd5));
		void'(enqueue(CMD_JOB_END, 3'd0, 32'hFFFF_FFFF));
		void'(enqueue(CMD_JOB_START, 3'd1, 32'd3));
		drain();

		program_regs(32'd1, 32'd1, 32'd0, 32'd0);
		void'(enqueue(CMD_BEGIN, 3'd0, 32'd100));
		void'(enqueue(CMD_JOB_END, 3'd4, 32'd100));
		void'(enqueue(CMD_JOB_END, 3'd4, 32'd100));
		void'(enqueue(CMD_JOB_START, 3'd0, 32'd101));
		drain();

		program_regs(32'd50, 32'd3000, $urandom_range(30000, 2000), $urandom_range(1000, 0));
		run_random(33, 600);
		drain();

		quiet = 1'b1;
		program_regs(32'd50, 32'd3000, $urandom_range(30000, 2000), $urandom_range(1000, 0));
		run_random(33, 600);
		drain();
		quiet = 1'b0;

		program_regs(32'd1, 32'hFFFF_FFFF, $urandom(), $urandom());
		run_random(33, 32'h7FFF_FFFF);
		drain();

		program_regs(32'd20, 32'd500, $urandom_range(5000, 500), $urandom_range(100, 0));
		run_random(33, 150);
		drain();

		$display("Covered %0d command beats over seven register settings, %0d result beats checked",
			cmds_taken, status_seen);
		$display("including %0d end-of-test summary beats", summaries_seen);
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
